>>> rtl/cenum_pkg.sv
// shared types and constants of the combination enumerator
package cenum_pkg;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FILL,
      ST_EMIT
   } state_type;

   // request modes
   localparam logic [1:0] MODE_LOAD    = 2'd0;
   localparam logic [1:0] MODE_RESTART = 2'd1;
   localparam logic [1:0] MODE_NEXT    = 2'd2;

   // register indexes
   localparam logic CSR_SET_SIZE  = 1'b0;
   localparam logic CSR_PICK_SIZE = 1'b1;

   // fixed field widths
   localparam int SET_SIZE_W  = 7;
   localparam int PICK_SIZE_W = 5;
   localparam int SLOT_W      = 4;
   localparam int INDEX_W     = 6;
   localparam int VALUE_W     = 64;

   localparam logic [SET_SIZE_W-1:0]  SET_SIZE_RST  = 7'd8;
   localparam logic [PICK_SIZE_W-1:0] PICK_SIZE_RST = 5'd2;

   // index vector commands
   typedef struct packed {
      logic restart;
      logic wr_cur;
      logic wr_next;
   } ivec_cmd_type;

endpackage

>>> rtl/combination_enumerator_unit.sv
// combination enumerator: value store, index vector and step sequencer
// load and restart transactions never raise busy
// next transaction: exhausted answer in the cycle after acceptance for bad sizes or a finished run; otherwise
//   busy for emit (first combination) or scan + fill + emit over the index vector (exhausted if scan finds none),
//   one element result per cycle, the last one in the first cycle with busy low again
// synchronous reset: sizes 8 and 2, index vector ascending, first combination pending;
//   the value store is not cleared, so there is no clearing pass
module combination_enumerator_unit import cenum_pkg::*; #(
   parameter int MAX_SET  = 64,
   parameter int MAX_PICK = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   // request transaction
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_mode,
   input  logic [INDEX_W-1:0]     req_load_index,
   input  logic [VALUE_W-1:0]     req_load_value,
   // result transaction
   output logic                   rsp_strobe,
   output logic [SLOT_W-1:0]      rsp_slot,
   output logic [INDEX_W-1:0]     rsp_element_index,
   output logic [VALUE_W-1:0]     rsp_element_value,
   output logic                   rsp_last_of_run,
   output logic                   rsp_exhausted,
   // register writes
   input  logic                   csr_write_enable,
   input  logic                   csr_index,
   input  logic [SET_SIZE_W-1:0]  csr_write_data
);

   // index width covers both the store depth and the ascending reset pattern
   localparam int IDX_W   = $clog2((MAX_SET > MAX_PICK) ? MAX_SET : MAX_PICK);
   localparam int PTR_W   = (MAX_PICK > 1) ? $clog2(MAX_PICK) : 1;
   localparam int ADDR_W  = $clog2(MAX_SET);
   localparam int SUM_MAX = MAX_SET + MAX_PICK;
   // arithmetic width for sizes, limits and compares
   localparam int AW      = $clog2(((SUM_MAX > 127) ? SUM_MAX : 127) + 1);

   // configuration registers
   logic [SET_SIZE_W-1:0]  set_size_ff;
   logic [PICK_SIZE_W-1:0] pick_size_ff;

   // sequencer state
   state_type  state_ff, state_in;
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic       first_ff, done_ff;

   // result registers
   logic                rsp_strobe_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic [INDEX_W-1:0]  rsp_index_ff;
   logic                rsp_last_ff;
   logic                rsp_exh_ff;
   logic                rsp_zero_ff;

   // datapath
   logic [AW-1:0]    n_eff, m_eff, set_ext, pick_ext, limit, cur_ext;
   logic [IDX_W-1:0] cur, cur_inc;
   logic [VALUE_W-1:0] store_rdata;
   logic             accept, is_load, is_restart, is_next;
   logic             bad_size, cur_below, ptr_last, ptr_zero;

   // sequencer outputs
   ivec_cmd_type iv_cmd;
   logic         store_we, emit_elem, emit_exh, set_done, clr_first;

   // ---------------------------------------------------------------
   // transaction decode
   // ---------------------------------------------------------------
   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign is_load    = accept && (req_mode == MODE_LOAD);
   assign is_restart = accept && (req_mode == MODE_RESTART);
   assign is_next    = accept && (req_mode == MODE_NEXT);

   // saturated sizes
   assign set_ext  = AW'(set_size_ff);
   assign pick_ext = AW'(pick_size_ff);
   assign n_eff    = (set_ext > AW'(MAX_SET)) ? AW'(MAX_SET) : set_ext;
   assign m_eff    = (pick_ext > AW'(MAX_PICK)) ? AW'(MAX_PICK) : pick_ext;
   assign bad_size = (m_eff == '0) || (m_eff > n_eff) || done_ff;

   // shared step unit: compare against the position limit and increment
   // limit = n - m + pos; nonnegative since m <= n whenever it is used
   assign cur_ext   = AW'(cur);
   assign limit     = n_eff + AW'(ptr_ff) - m_eff;
   assign cur_below = (cur_ext < limit);
   assign cur_inc   = cur + IDX_W'(1);
   assign ptr_last  = ((AW'(ptr_ff) + AW'(1)) == m_eff);
   assign ptr_zero  = (ptr_ff == '0);

   // ---------------------------------------------------------------
   // configuration port
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         set_size_ff  <= SET_SIZE_RST;
         pick_size_ff <= PICK_SIZE_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SET_SIZE: begin
               set_size_ff <= csr_write_data;
            end
            CSR_PICK_SIZE: begin
               pick_size_ff <= csr_write_data[PICK_SIZE_W-1:0];
            end
         endcase
      end
   end

   // ---------------------------------------------------------------
   // next state
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (is_next && !bad_size) begin
               state_in = first_ff ? ST_EMIT : ST_SCAN;
            end
         end
         ST_SCAN: begin
            // walk down from the last position to the first one that can grow
            if (cur_below) begin
               state_in = ST_FILL;
            end else if (ptr_zero) begin
               state_in = ST_IDLE;
            end
         end
         ST_FILL: begin
            if (ptr_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (ptr_last) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // ---------------------------------------------------------------
   // sequencer outputs
   // ---------------------------------------------------------------
   always_comb begin
      iv_cmd.restart = is_restart;
      iv_cmd.wr_cur  = 1'b0;
      iv_cmd.wr_next = 1'b0;
      store_we       = is_load && (AW'(req_load_index) < AW'(MAX_SET));
      emit_elem      = 1'b0;
      emit_exh       = 1'b0;
      set_done       = 1'b0;
      clr_first      = 1'b0;
      ptr_in         = ptr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (is_next) begin
               if (bad_size) begin
                  emit_exh = 1'b1;
               end else if (first_ff) begin
                  clr_first = 1'b1;
                  ptr_in    = '0;
               end else begin
                  ptr_in = PTR_W'(m_eff - AW'(1));
               end
            end
         end
         ST_SCAN: begin
            if (cur_below) begin
               iv_cmd.wr_cur = 1'b1;
            end else if (ptr_zero) begin
               // no successor left
               set_done = 1'b1;
               emit_exh = 1'b1;
            end else begin
               ptr_in = ptr_ff - PTR_W'(1);
            end
         end
         ST_FILL: begin
            // later positions follow the grown one in ascending steps
            if (ptr_last) begin
               ptr_in = '0;
            end else begin
               iv_cmd.wr_next = 1'b1;
               ptr_in         = ptr_ff + PTR_W'(1);
            end
         end
         ST_EMIT: begin
            emit_elem = 1'b1;
            ptr_in    = ptr_ff + PTR_W'(1);
         end
      endcase
   end

   // ---------------------------------------------------------------
   // sequencer registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ptr_ff   <= '0;
         first_ff <= 1'b1;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
         if (is_restart) begin
            first_ff <= 1'b1;
            done_ff  <= 1'b0;
         end else begin
            if (clr_first) begin
               first_ff <= 1'b0;
            end
            if (set_done) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // index vector and value store
   // ---------------------------------------------------------------
   cenum_ivec #(
      .DEPTH (MAX_PICK),
      .IDX_W (IDX_W)
   ) u_ivec (
      .clock   (clock),
      .reset   (reset),
      .cmd     (iv_cmd),
      .ptr     (ptr_ff),
      .wr_data (cur_inc),
      .rd_data (cur)
   );

   cenum_store #(
      .DEPTH (MAX_SET)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (ADDR_W'(req_load_index)),
      .wr_data (req_load_value),
      .rd_en   (emit_elem),
      .rd_addr (ADDR_W'(cur)),
      .rd_data (store_rdata)
   );

   // ---------------------------------------------------------------
   // result registers, aligned with the store read
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= emit_elem || emit_exh;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_elem) begin
         rsp_slot_ff  <= SLOT_W'(ptr_ff);
         rsp_index_ff <= INDEX_W'(cur);
         rsp_last_ff  <= ptr_last;
         rsp_exh_ff   <= 1'b0;
         // index past the store reads as zero
         rsp_zero_ff  <= (cur_ext >= AW'(MAX_SET));
      end else if (emit_exh) begin
         rsp_slot_ff  <= '0;
         rsp_index_ff <= '0;
         rsp_last_ff  <= 1'b0;
         rsp_exh_ff   <= 1'b1;
         rsp_zero_ff  <= 1'b1;
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_element_index = rsp_index_ff;
   assign rsp_element_value = rsp_zero_ff ? '0 : store_rdata;
   assign rsp_last_of_run   = rsp_last_ff;
   assign rsp_exhausted     = rsp_exh_ff;

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
`ifndef SYNTH
   a_exh_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_exhausted) |-> (rsp_slot == '0 && rsp_element_index == '0 &&
         !rsp_last_of_run && rsp_element_value == '0))
      else $error("exhausted transaction carries nonzero fields");

   a_emit_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (AW'(ptr_ff) < m_eff))
      else $error("emit pointer beyond pick size");

   a_last_follows_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && ptr_last) |=> (rsp_strobe && rsp_last_of_run))
      else $error("final element missing last_of_run");

   a_busy_end_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("busy dropped without a result");
`endif

endmodule

>>> rtl/cenum_store.sv
// value word memory with one write port and one registered read port
module cenum_store import cenum_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [VALUE_W-1:0]       wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [VALUE_W-1:0]       rd_data
);

   logic [VALUE_W-1:0] value_mem_ff [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         value_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= value_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/cenum_ivec.sv
// index vector register file, one read port at the pointer
module cenum_ivec import cenum_pkg::*; #(
   parameter int DEPTH = 16,
   parameter int IDX_W = 6,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  ivec_cmd_type     cmd,
   input  logic [PTR_W-1:0] ptr,
   input  logic [IDX_W-1:0] wr_data,
   output logic [IDX_W-1:0] rd_data
);

   logic [IDX_W-1:0] iv_ff [DEPTH];
   logic [PTR_W-1:0] ptr_next;

   assign ptr_next = ptr + PTR_W'(1);

   always_ff @(posedge clock) begin
      if (reset || cmd.restart) begin
         for (int i = 0; i < DEPTH; i++) begin
            iv_ff[i] <= IDX_W'(i);
         end
      end else begin
         if (cmd.wr_cur) begin
            iv_ff[ptr] <= wr_data;
         end
         if (cmd.wr_next) begin
            iv_ff[ptr_next] <= wr_data;
         end
      end
   end

   assign rd_data = iv_ff[ptr];

endmodule
